@@ rtl/gtsf_pkg.sv @@
// ----------------------------------------------------------------------------
// gtsf_pkg
// Shared types, constants and fixed-point helpers for the tone shaping filter.
// ----------------------------------------------------------------------------
package gtsf_pkg;

   // sample and state formats
   localparam int SAMPLE_W    = 16;                     // Q1.15
   localparam int STATE_W     = 32;                     // Q5.27
   localparam int STATE_FRAC  = STATE_W - 5;
   localparam int ALIGN_SHIFT = STATE_FRAC - (SAMPLE_W - 1);
   localparam int GAIN_FRAC   = 24;
   localparam int COEF_FRAC   = 22;

   // shared multiplier geometry
   localparam int OPA_W   = STATE_W + 3;                // widest filter operand
   localparam int OPB_W   = 25;                         // gains and coefficients
   localparam int CHUNK_W = 12;                         // low slice of operand b
   localparam int MB_W    = OPB_W - CHUNK_W;            // signed slice width
   localparam int PROD_W  = OPA_W + MB_W;
   localparam int ACC_W   = 62;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int COEF_W     = 24;
   localparam int RSQ_W      = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_RESONANCE_COEF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQUARED = 2'd1;

   localparam logic [COEF_W-1:0] COEF_RESET = 24'd7481087;
   localparam logic [RSQ_W-1:0]  RSQ_RESET  = 23'd4081824;

   // unsigned Q0.24 gains, carried as signed multiplier operands
   localparam logic signed [OPB_W-1:0] G_HP_POLE  = 25'sd16693330;  // 0.995
   localparam logic signed [OPB_W-1:0] G_PRESENCE = 25'sd2684355;   // 0.16
   localparam logic signed [OPB_W-1:0] G_BODY_LP  = 25'sd587203;    // 0.035
   localparam logic signed [OPB_W-1:0] G_MIX_HP   = 25'sd12079596;  // 0.72
   localparam logic signed [OPB_W-1:0] G_MIX_PRES = 25'sd10401874;  // 0.62
   localparam logic signed [OPB_W-1:0] G_MIX_RES  = 25'sd46976;     // 0.0028
   localparam logic signed [OPB_W-1:0] G_OUTPUT   = 25'sd13086228;  // 0.78

   typedef enum logic [3:0] {
      OP_HP,
      OP_PRES,
      OP_BODY,
      OP_RES_FB,
      OP_RES_RSQ,
      OP_MIX_HP,
      OP_MIX_BODY,
      OP_MIX_PRES,
      OP_MIX_RES,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_WB
   } state_type;

   typedef struct packed {
      logic   idle;
      logic   load;
      logic   mul_lo;
      logic   mul_hi;
      logic   acc_clear;
      logic   wb;
      op_type op;
   } ctrl_type;

   // add half, then arithmetic shift (ties toward plus infinity)
   function automatic logic signed [ACC_W-1:0] round_shift(
      input logic signed [ACC_W-1:0] v,
      input int unsigned             n
   );
      logic signed [ACC_W-1:0] half;
      half = ACC_W'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[STATE_W-1:0];
      end else if (v < lo) begin
         return lo[STATE_W-1:0];
      end
      return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[SAMPLE_W-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_W-1:0];
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

@@ rtl/gtsf_mac.sv @@
// ----------------------------------------------------------------------------
// gtsf_mac
// Shared multiply-accumulate unit: operand b is taken in two slices.
// ----------------------------------------------------------------------------
module gtsf_mac (
   input  logic                                   clock,
   input  gtsf_pkg::ctrl_type                     ctrl,
   input  logic signed [gtsf_pkg::OPA_W-1:0]      opa,
   input  logic signed [gtsf_pkg::OPB_W-1:0]      opb,
   output logic signed [gtsf_pkg::ACC_W-1:0]      acc
);

   logic signed [gtsf_pkg::OPA_W-1:0]  opa_ff;
   logic signed [gtsf_pkg::OPB_W-1:0]  opb_ff;
   logic signed [gtsf_pkg::ACC_W-1:0]  acc_ff;
   logic signed [gtsf_pkg::ACC_W-1:0]  acc_in;
   logic signed [gtsf_pkg::MB_W-1:0]   slice;
   logic signed [gtsf_pkg::PROD_W-1:0] prod;
   logic signed [gtsf_pkg::ACC_W-1:0]  addend;
   logic signed [gtsf_pkg::ACC_W-1:0]  base;

   // low slice unsigned, high slice carries the sign
   always_comb begin
      if (ctrl.mul_hi) begin
         slice = opb_ff[gtsf_pkg::OPB_W-1:gtsf_pkg::CHUNK_W];
      end else begin
         slice = {1'b0, opb_ff[gtsf_pkg::CHUNK_W-1:0]};
      end
   end

   assign prod = opa_ff * slice;

   always_comb begin
      addend = gtsf_pkg::ACC_W'(prod);
      if (ctrl.mul_hi) begin
         addend = addend <<< gtsf_pkg::CHUNK_W;
      end
      base   = ctrl.acc_clear ? '0 : acc_ff;
      acc_in = base + addend;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         opa_ff <= opa;
         opb_ff <= opb;
      end
      if (ctrl.mul_lo || ctrl.mul_hi) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

@@ rtl/gtsf_seq.sv @@
// ----------------------------------------------------------------------------
// gtsf_seq
// Sequencer that walks the ten products of one sample through the MAC.
// ----------------------------------------------------------------------------
module gtsf_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_free,
   output gtsf_pkg::ctrl_type ctrl
);

   gtsf_pkg::state_type st_ff;
   gtsf_pkg::state_type st_in;
   gtsf_pkg::op_type    op_ff;
   gtsf_pkg::op_type    op_in;
   gtsf_pkg::op_type    op_next;
   logic                needs_wb;
   logic                chained;

   assign op_next = gtsf_pkg::op_type'(op_ff + 4'd1);

   // mix terms sum into one accumulation
   assign needs_wb = !(op_ff == gtsf_pkg::OP_MIX_HP || op_ff == gtsf_pkg::OP_MIX_BODY ||
                       op_ff == gtsf_pkg::OP_MIX_PRES);
   assign chained  = (op_ff == gtsf_pkg::OP_MIX_BODY || op_ff == gtsf_pkg::OP_MIX_PRES ||
                      op_ff == gtsf_pkg::OP_MIX_RES);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= gtsf_pkg::ST_IDLE;
         op_ff <= gtsf_pkg::OP_HP;
      end else begin
         st_ff <= st_in;
         op_ff <= op_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      op_in = op_ff;
      case (st_ff)
         gtsf_pkg::ST_IDLE: begin
            if (start) begin
               st_in = gtsf_pkg::ST_LOAD;
               op_in = gtsf_pkg::OP_HP;
            end
         end
         gtsf_pkg::ST_LOAD: begin
            st_in = gtsf_pkg::ST_MUL_LO;
         end
         gtsf_pkg::ST_MUL_LO: begin
            st_in = gtsf_pkg::ST_MUL_HI;
         end
         gtsf_pkg::ST_MUL_HI: begin
            if (needs_wb) begin
               st_in = gtsf_pkg::ST_WB;
            end else begin
               st_in = gtsf_pkg::ST_LOAD;
               op_in = op_next;
            end
         end
         gtsf_pkg::ST_WB: begin
            if (op_ff == gtsf_pkg::OP_OUT) begin
               if (out_free) begin
                  st_in = gtsf_pkg::ST_IDLE;
               end
            end else begin
               st_in = gtsf_pkg::ST_LOAD;
               op_in = op_next;
            end
         end
         default: begin
            st_in = gtsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl    = '0;
      ctrl.op = op_ff;
      case (st_ff)
         gtsf_pkg::ST_IDLE: begin
            ctrl.idle = 1'b1;
         end
         gtsf_pkg::ST_LOAD: begin
            ctrl.load = 1'b1;
         end
         gtsf_pkg::ST_MUL_LO: begin
            ctrl.mul_lo    = 1'b1;
            ctrl.acc_clear = !chained;
         end
         gtsf_pkg::ST_MUL_HI: begin
            ctrl.mul_hi = 1'b1;
         end
         gtsf_pkg::ST_WB: begin
            // final write waits for room in the response register
            ctrl.wb = (op_ff != gtsf_pkg::OP_OUT) || out_free;
         end
         default: begin
            ctrl.idle = 1'b0;
         end
      endcase
   end

   a_lo_then_hi: assert property (@(posedge clock) disable iff (reset)
      st_ff == gtsf_pkg::ST_MUL_LO |=> st_ff == gtsf_pkg::ST_MUL_HI)
      else $error("low slice not followed by high slice");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == gtsf_pkg::ST_WB && op_ff == gtsf_pkg::OP_OUT && !out_free)
      |=> (st_ff == gtsf_pkg::ST_WB && op_ff == gtsf_pkg::OP_OUT))
      else $error("final writeback left while response register full");

endmodule

@@ rtl/guitar_tone_shaping_filter.sv @@
// ----------------------------------------------------------------------------
// guitar_tone_shaping_filter
// DC blocker, presence and body low-passes and a two-pole pickup resonator,
// mixed, scaled and saturated to one Q1.15 sample per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_sample_in   (Q1.15)
//  rsp      out        rsp_valid/rsp_ready  rsp_sample_out  (Q1.15, saturated)
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
//  - ten products per request through one shared 35x13 multiplier, each an
//    operand load then a low and a high slice step, with a writeback after
//    every product except the first three mix terms, then back to idle
//  - req_ready is high only while the sequencer is idle
//  - the result sits in an output register, so a new request is taken while
//    it waits; the next result stalls in its final writeback until rsp is free
//  - reset clears the filter state and loads the register defaults; no
//    clearing pass, csr is always ready
// ----------------------------------------------------------------------------
module guitar_tone_shaping_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [gtsf_pkg::SAMPLE_W-1:0]    req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [gtsf_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [gtsf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gtsf_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   gtsf_pkg::ctrl_type ctrl;

   // configuration registers
   logic signed [gtsf_pkg::COEF_W-1:0] coef_ff;
   logic [gtsf_pkg::RSQ_W-1:0]         rsq_ff;

   // filter state, Q5.27
   logic signed [gtsf_pkg::SAMPLE_W-1:0] last_input_ff;
   logic signed [gtsf_pkg::STATE_W-1:0]  hp_ff;
   logic signed [gtsf_pkg::STATE_W-1:0]  pres_ff;
   logic signed [gtsf_pkg::STATE_W-1:0]  body_ff;
   logic signed [gtsf_pkg::STATE_W-1:0]  d1_ff;
   logic signed [gtsf_pkg::STATE_W-1:0]  d2_ff;

   // per-sample temporaries
   logic signed [gtsf_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [gtsf_pkg::OPA_W-1:0]    fb_ff;
   logic signed [gtsf_pkg::OPA_W-1:0]    pick_ff;
   logic signed [gtsf_pkg::OPA_W-1:0]    shaped_ff;

   // response register
   logic                                 rsp_valid_ff;
   logic signed [gtsf_pkg::SAMPLE_W-1:0] rsp_sample_ff;

   // next values
   logic signed [gtsf_pkg::STATE_W-1:0]  hp_in;
   logic signed [gtsf_pkg::STATE_W-1:0]  pres_in;
   logic signed [gtsf_pkg::STATE_W-1:0]  body_in;
   logic signed [gtsf_pkg::STATE_W-1:0]  res_in;
   logic signed [gtsf_pkg::OPA_W-1:0]    fb_in;
   logic signed [gtsf_pkg::OPA_W-1:0]    pick_in;
   logic signed [gtsf_pkg::OPA_W-1:0]    shaped_in;
   logic signed [gtsf_pkg::SAMPLE_W-1:0] out_in;

   logic signed [gtsf_pkg::OPA_W-1:0]    x_ext;
   logic signed [gtsf_pkg::OPA_W-1:0]    px_ext;
   logic signed [gtsf_pkg::OPA_W-1:0]    presence_ext;
   logic signed [gtsf_pkg::OPA_W-1:0]    opa;
   logic signed [gtsf_pkg::OPB_W-1:0]    opb;
   logic signed [gtsf_pkg::ACC_W-1:0]    acc;
   logic signed [gtsf_pkg::ACC_W-1:0]    acc_g;
   logic signed [gtsf_pkg::ACC_W-1:0]    acc_c;

   logic req_fire;
   logic out_free;
   logic out_write;

   assign req_ready = ctrl.idle;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_write = ctrl.wb && (ctrl.op == gtsf_pkg::OP_OUT);
   assign csr_ready = 1'b1;

   gtsf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   gtsf_mac u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .opa   (opa),
      .opb   (opb),
      .acc   (acc)
   );

   // configuration writes, out-of-range indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= gtsf_pkg::COEF_RESET;
         rsq_ff  <= gtsf_pkg::RSQ_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gtsf_pkg::CSR_RESONANCE_COEF: coef_ff <= csr_wdata[gtsf_pkg::COEF_W-1:0];
            gtsf_pkg::CSR_RADIUS_SQUARED: rsq_ff  <= csr_wdata[gtsf_pkg::RSQ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // samples aligned into the state format
   assign x_ext        = gtsf_pkg::OPA_W'(sample_ff) <<< gtsf_pkg::ALIGN_SHIFT;
   assign px_ext       = gtsf_pkg::OPA_W'(last_input_ff) <<< gtsf_pkg::ALIGN_SHIFT;
   assign presence_ext = gtsf_pkg::OPA_W'(hp_ff) - gtsf_pkg::OPA_W'(pres_ff);

   // operand select for the product about to run
   always_comb begin
      case (ctrl.op)
         gtsf_pkg::OP_HP: begin
            opa = gtsf_pkg::OPA_W'(hp_ff) + x_ext - px_ext;
            opb = gtsf_pkg::G_HP_POLE;
         end
         gtsf_pkg::OP_PRES: begin
            opa = presence_ext;
            opb = gtsf_pkg::G_PRESENCE;
         end
         gtsf_pkg::OP_BODY: begin
            opa = x_ext - gtsf_pkg::OPA_W'(body_ff);
            opb = gtsf_pkg::G_BODY_LP;
         end
         gtsf_pkg::OP_RES_FB: begin
            opa = gtsf_pkg::OPA_W'(d1_ff);
            opb = gtsf_pkg::OPB_W'(coef_ff);
         end
         gtsf_pkg::OP_RES_RSQ: begin
            opa = gtsf_pkg::OPA_W'(d2_ff);
            opb = signed'(gtsf_pkg::OPB_W'(rsq_ff));
         end
         gtsf_pkg::OP_MIX_HP: begin
            opa = gtsf_pkg::OPA_W'(hp_ff);
            opb = gtsf_pkg::G_MIX_HP;
         end
         gtsf_pkg::OP_MIX_BODY: begin
            // body term of the mix uses the presence gain
            opa = gtsf_pkg::OPA_W'(body_ff);
            opb = gtsf_pkg::G_PRESENCE;
         end
         gtsf_pkg::OP_MIX_PRES: begin
            opa = presence_ext;
            opb = gtsf_pkg::G_MIX_PRES;
         end
         gtsf_pkg::OP_MIX_RES: begin
            opa = pick_ff;
            opb = gtsf_pkg::G_MIX_RES;
         end
         gtsf_pkg::OP_OUT: begin
            opa = shaped_ff;
            opb = gtsf_pkg::G_OUTPUT;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // writeback arithmetic, each accumulation rounded on its own
   always_comb begin
      acc_g     = gtsf_pkg::round_shift(acc, gtsf_pkg::GAIN_FRAC);
      acc_c     = gtsf_pkg::round_shift(acc, gtsf_pkg::COEF_FRAC);
      hp_in     = gtsf_pkg::sat_state(acc_g);
      pres_in   = gtsf_pkg::sat_state(gtsf_pkg::ACC_W'(pres_ff) + acc_g);
      body_in   = gtsf_pkg::sat_state(gtsf_pkg::ACC_W'(body_ff) + acc_g);
      fb_in     = gtsf_pkg::OPA_W'(acc_c);
      res_in    = gtsf_pkg::sat_state(gtsf_pkg::ACC_W'(hp_ff) + gtsf_pkg::ACC_W'(fb_ff)
                                      - acc_c);
      // pickup resonance: new resonator output minus the value two samples back
      pick_in   = gtsf_pkg::OPA_W'(res_in) - gtsf_pkg::OPA_W'(d2_ff);
      shaped_in = gtsf_pkg::OPA_W'(acc_g);
      out_in    = gtsf_pkg::sat_sample(gtsf_pkg::round_shift(acc_g, gtsf_pkg::ALIGN_SHIFT));
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_input_ff <= '0;
         hp_ff         <= '0;
         pres_ff       <= '0;
         body_ff       <= '0;
         d1_ff         <= '0;
         d2_ff         <= '0;
      end else if (ctrl.wb) begin
         case (ctrl.op)
            gtsf_pkg::OP_HP: begin
               hp_ff         <= hp_in;
               last_input_ff <= sample_ff;
            end
            gtsf_pkg::OP_PRES: begin
               pres_ff <= pres_in;
            end
            gtsf_pkg::OP_BODY: begin
               body_ff <= body_in;
            end
            gtsf_pkg::OP_RES_RSQ: begin
               d1_ff <= res_in;
               d2_ff <= d1_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // per-sample temporaries
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_sample_in;
      end
      if (ctrl.wb && ctrl.op == gtsf_pkg::OP_RES_FB) begin
         fb_ff <= fb_in;
      end
      if (ctrl.wb && ctrl.op == gtsf_pkg::OP_RES_RSQ) begin
         pick_ff <= pick_in;
      end
      if (ctrl.wb && ctrl.op == gtsf_pkg::OP_MIX_RES) begin
         shaped_ff <= shaped_in;
      end
      if (out_write) begin
         rsp_sample_ff <= out_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while a sample is in flight");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      out_write |=> rsp_valid_ff)
      else $error("final writeback did not post a response");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for guitar_tone_shaping_filter: a directed table of
// samples, then random audio across several resonator settings, with random
// request gaps and response stalls. Every response is checked against a
// fixed-point filter predictor held inside the bench.
// ----------------------------------------------------------------------------
module tb;

   // register indexes that the block must ignore
   localparam logic [gtsf_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [gtsf_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // gains widened once for the predictor arithmetic
   localparam longint K_HP_POLE  = gtsf_pkg::G_HP_POLE;
   localparam longint K_PRESENCE = gtsf_pkg::G_PRESENCE;
   localparam longint K_BODY_LP  = gtsf_pkg::G_BODY_LP;
   localparam longint K_MIX_HP   = gtsf_pkg::G_MIX_HP;
   localparam longint K_MIX_PRES = gtsf_pkg::G_MIX_PRES;
   localparam longint K_MIX_RES  = gtsf_pkg::G_MIX_RES;
   localparam longint K_OUTPUT   = gtsf_pkg::G_OUTPUT;

   localparam int SETTLE_CYCLES = 48;     // longer than one sequencer pass
   localparam int ITEMS_PER_PHASE = 240;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic signed [gtsf_pkg::SAMPLE_W-1:0]    req_sample_in = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [gtsf_pkg::SAMPLE_W-1:0]    rsp_sample_out;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [gtsf_pkg::CSR_IDX_W-1:0]          csr_index = '0;
   logic [gtsf_pkg::CSR_DATA_W-1:0]         csr_wdata = '0;

   always #4 clock = ~clock;

   guitar_tone_shaping_filter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // filter predictor: own copy of registers and filter state
   // ------------------------------------------------------------------------
   logic [gtsf_pkg::COEF_W-1:0]          coef_shadow = gtsf_pkg::COEF_RESET;
   logic [gtsf_pkg::RSQ_W-1:0]           rsq_shadow  = gtsf_pkg::RSQ_RESET;
   logic signed [gtsf_pkg::SAMPLE_W-1:0] prev_sample = '0;
   longint                  hp_state    = 0;
   longint                  pres_state  = 0;
   longint                  body_state  = 0;
   longint                  reso_z1     = 0;
   longint                  reso_z2     = 0;

   logic signed [gtsf_pkg::SAMPLE_W-1:0] expected_q[$];
   int                      error_count  = 0;
   int                      sent_count   = 0;
   int                      result_count = 0;
   int                      write_count  = 0;
   int                      clip_count   = 0;

   // add half, then floor shift
   function automatic longint round_off(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic logic signed [gtsf_pkg::SAMPLE_W-1:0] shape_sample(
      input logic signed [gtsf_pkg::SAMPLE_W-1:0] s
   );
      longint x;
      longint px;
      longint coef;
      longint rsq;
      longint next_reso;
      longint pickup;
      longint presence;
      longint mix;
      longint shaped;
      longint y;
      x    = longint'(s) <<< gtsf_pkg::ALIGN_SHIFT;
      px   = longint'(prev_sample) <<< gtsf_pkg::ALIGN_SHIFT;
      coef = longint'($signed(coef_shadow));
      rsq  = longint'(rsq_shadow);

      // dc blocker
      hp_state = clamp(round_off(K_HP_POLE * (hp_state + x - px), gtsf_pkg::GAIN_FRAC),
                       gtsf_pkg::STATE_W);
      prev_sample = s;

      // presence follows the high-passed signal, body follows the raw input
      pres_state = clamp(pres_state +
         round_off(K_PRESENCE * (hp_state - pres_state), gtsf_pkg::GAIN_FRAC),
         gtsf_pkg::STATE_W);
      body_state = clamp(body_state +
         round_off(K_BODY_LP * (x - body_state), gtsf_pkg::GAIN_FRAC), gtsf_pkg::STATE_W);

      // two-pole pickup resonator
      next_reso = clamp(hp_state + round_off(coef * reso_z1, gtsf_pkg::COEF_FRAC)
                        - round_off(rsq * reso_z2, gtsf_pkg::COEF_FRAC), gtsf_pkg::STATE_W);
      pickup  = next_reso - reso_z2;
      reso_z2 = reso_z1;
      reso_z1 = next_reso;

      // mix uses the presence gain on the body term
      presence = hp_state - pres_state;
      mix = K_MIX_HP * hp_state + K_PRESENCE * body_state
          + K_MIX_PRES * presence + K_MIX_RES * pickup;
      shaped = round_off(mix, gtsf_pkg::GAIN_FRAC);
      y = round_off(K_OUTPUT * shaped, gtsf_pkg::GAIN_FRAC);
      y = clamp(round_off(y, gtsf_pkg::ALIGN_SHIFT), gtsf_pkg::SAMPLE_W);
      return y[gtsf_pkg::SAMPLE_W-1:0];
   endfunction

   // wait count per item, with every third stretch of 32 items running flat out
   function automatic int pick_wait(input int n);
      if ((n / 32) % 3 == 2) begin
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_sample(
      input logic signed [gtsf_pkg::SAMPLE_W-1:0] s,
      input bit                                   known,
      input logic signed [gtsf_pkg::SAMPLE_W-1:0] want,
      input bit                                   drain
   );
      int gap;
      logic signed [gtsf_pkg::SAMPLE_W-1:0] predicted;
      gap = pick_wait(sent_count);
      // a drain must take the gap, so valid drops while the queue empties
      if (drain && gap == 0) begin
         gap = 1;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (drain) begin
            while (expected_q.size() != 0) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
      predicted = shape_sample(s);
      expected_q.push_back(known ? want : predicted);
      sent_count++;
   endtask

   // block is idle once every response is back and the sequencer has settled
   task automatic wait_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid is left high; the caller drops it after the last write of a batch
   task automatic write_reg(input logic [gtsf_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [gtsf_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gtsf_pkg::CSR_RESONANCE_COEF: coef_shadow = data[gtsf_pkg::COEF_W-1:0];
         gtsf_pkg::CSR_RADIUS_SQUARED: rsq_shadow  = data[gtsf_pkg::RSQ_W-1:0];
         default: ;
      endcase
      write_count++;
   endtask

   // random audio: mostly full range, some quiet passages, rails and dc holds
   function automatic logic signed [gtsf_pkg::SAMPLE_W-1:0] draw_sample(
      input logic signed [gtsf_pkg::SAMPLE_W-1:0] last
   );
      case ($urandom_range(0, 9))
         6, 7:    return gtsf_pkg::SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
         8:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         9:       return last;
         default: return gtsf_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic run_random(input int n);
      logic signed [gtsf_pkg::SAMPLE_W-1:0] s;
      s = '0;
      for (int i = 0; i < n; i++) begin
         s = draw_sample(s);
         send_sample(s, 1'b0, '0, $urandom_range(0, 149) == 0);
      end
      req_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // directed table: zeros after reset have a known answer of zero, the rest
   // go through the predictor
   // ------------------------------------------------------------------------
   typedef struct {
      logic signed [gtsf_pkg::SAMPLE_W-1:0] sample;
      bit                                   known;
      logic signed [gtsf_pkg::SAMPLE_W-1:0] want;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{16'sh0000, 1'b1, 16'sh0000},   // silence straight out of reset
      '{16'sh0000, 1'b1, 16'sh0000},
      '{16'sh7fff, 1'b0, 16'sh0000},   // full-scale positive step
      '{16'sh7fff, 1'b0, 16'sh0000},   // held, dc blocker starts to decay
      '{16'sh7fff, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 16'sh0000},   // rail to rail swing, output clips
      '{16'sh8000, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 16'sh0000},
      '{16'sh7fff, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 16'sh0000},
      '{16'sh0001, 1'b0, 16'sh0000},   // smallest magnitudes
      '{16'shffff, 1'b0, 16'sh0000},
      '{16'sh5555, 1'b0, 16'sh0000},   // alternating bit patterns
      '{16'shaaaa, 1'b0, 16'sh0000},
      '{16'sh4000, 1'b0, 16'sh0000},
      '{16'shc000, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 16'sh0000},   // ring down
      '{16'sh0000, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 16'sh0000}
   };

   // ------------------------------------------------------------------------
   // response side: random stalls, every response checked in order
   // ------------------------------------------------------------------------
   initial begin : response_side
      int stall;
      logic signed [gtsf_pkg::SAMPLE_W-1:0] want;
      wait (reset === 1'b0);
      forever begin
         stall = pick_wait(result_count);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %0d", $time,
                     rsp_sample_out);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_sample_out !== want) begin
               $display("%0t: sample_out mismatch expected %0d actual %0d", $time,
                        want, rsp_sample_out);
               error_count++;
            end
         end
         if (rsp_sample_out == 16'sh7fff || rsp_sample_out == 16'sh8000) begin
            clip_count++;
         end
         result_count++;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values, directed rows first
      foreach (directed[i]) begin
         send_sample(directed[i].sample, directed[i].known, directed[i].want, 1'b0);
      end
      run_random(ITEMS_PER_PHASE - directed.size());

      // both registers at their maximum: unstable resonator, state saturates
      wait_idle();
      write_reg(gtsf_pkg::CSR_RESONANCE_COEF, 24'h7fffff);
      write_reg(gtsf_pkg::CSR_RADIUS_SQUARED, 24'h7fffff);
      csr_valid <= 1'b0;
      run_random(ITEMS_PER_PHASE);

      // most negative coefficient, zero radius
      wait_idle();
      write_reg(gtsf_pkg::CSR_RESONANCE_COEF, 24'h800000);
      write_reg(gtsf_pkg::CSR_RADIUS_SQUARED, 24'h000000);
      csr_valid <= 1'b0;
      run_random(ITEMS_PER_PHASE);

      // random register data, writes to spare indexes must be ignored
      wait_idle();
      write_reg(gtsf_pkg::CSR_RESONANCE_COEF, gtsf_pkg::CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_A, gtsf_pkg::CSR_DATA_W'($urandom));
      write_reg(gtsf_pkg::CSR_RADIUS_SQUARED, gtsf_pkg::CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_B, gtsf_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      run_random(ITEMS_PER_PHASE);

      // back to defaults, radius written with its unused top bit set
      wait_idle();
      write_reg(CSR_SPARE_B, 24'hffffff);
      write_reg(gtsf_pkg::CSR_RESONANCE_COEF,
                gtsf_pkg::CSR_DATA_W'(gtsf_pkg::COEF_RESET));
      write_reg(gtsf_pkg::CSR_RADIUS_SQUARED,
                24'h800000 | gtsf_pkg::CSR_DATA_W'(gtsf_pkg::RSQ_RESET));
      write_reg(CSR_SPARE_A, 24'h000000);
      csr_valid <= 1'b0;
      run_random(ITEMS_PER_PHASE);

      // drain and give any stray response time to show up
      wait_idle();

      if (expected_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_q.size());
         error_count++;
      end
      $display("covered %0d samples over five resonator settings, %0d responses checked",
               sent_count, result_count);
      $display("%0d register writes incl. spare indexes, %0d clipped outputs, %0d errors",
               write_count, clip_count, error_count);
      if (error_count == 0) begin
         $display("guitar_tone_shaping_filter test passed");
      end else begin
         $display("guitar_tone_shaping_filter test failed");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #4000000;
      $display("guitar_tone_shaping_filter test failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/gtsf_pkg.sv
rtl/gtsf_mac.sv
rtl/gtsf_seq.sv
rtl/guitar_tone_shaping_filter.sv
dv/tb.sv
